// ----- rtl/ldws_pkg.sv -----
`timescale 1ns / 1ps
package ldws_pkg;

  localparam int unsigned LayerCount = 5;
  localparam int unsigned HeldLayers = (LayerCount < 2) ? 2 : ((LayerCount > 5) ? 5 : LayerCount);
  localparam int unsigned LayerW = 3;

  localparam logic [63:0] Ln2Q30    = 64'd744261118;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] Q30One    = 64'd1 << 30;
  localparam int unsigned SampleMax = 32767;

  // register indexes (byte address / 8)
  typedef enum logic [2:0] {
    REG_INNER_BOUNDS = 3'd0,
    REG_OUTER_BOUND  = 3'd1,
    REG_ABSORB       = 3'd2,
    REG_STEP_LOW     = 3'd3,
    REG_STEP_HIGH    = 3'd4,
    REG_DRIFT_LOW    = 3'd5,
    REG_DRIFT_HIGH   = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] inner_bounds;
    logic [15:0] outer_bound;
    logic [31:0] absorb_threshold;
    logic [59:0] step_size_low;
    logic [39:0] step_size_high;
    logic [59:0] drift_low;
    logic [39:0] drift_high;
  } cfg_t;

  function automatic logic [39:0] bound_at(input logic [63:0] ib, input int unsigned i);
    logic [39:0] b;
    b = {ib[16*(i%4) +: 16], 24'd0};
    return b;
  endfunction

  function automatic logic [19:0] field20(input logic [59:0] lo, input logic [39:0] hi,
                                          input logic [LayerW-1:0] i);
    logic [19:0] f;
    case (i)
      3'd0: f = lo[19:0];
      3'd1: f = lo[39:20];
      3'd2: f = lo[59:40];
      3'd3: f = hi[19:0];
      3'd4: f = hi[39:20];
      default: f = 20'd0;
    endcase
    return f;
  endfunction

  // first-match layer search
  function automatic logic [LayerW-1:0] layer_of(input logic [63:0] ib, input logic [40:0] p);
    logic [LayerW-1:0] l;
    logic found;
    l = LayerW'(HeldLayers - 1);
    found = 1'b0;
    for (int i = 0; i < HeldLayers - 1; i++) begin
      if (!found && (p < {1'b0, bound_at(ib, i)})) begin
        l = LayerW'(i);
        found = 1'b1;
      end
    end
    return l;
  endfunction

endpackage

// ----- rtl/ldws_gauss.sv -----
`timescale 1ns / 1ps
// Pipelined Box-Muller sample: log by squaring (one bit per stage), sqrt one
// bit per stage, cos/sin by Horner with one multiply or one constant divide
// per stage, riding alongside the square root.
module ldws_gauss
  import ldws_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [23:0]        radius_i,
  input  logic [23:0]        angle_i,
  output logic signed [16:0] sample_o
);

  localparam int unsigned LogSt = 20;
  localparam int unsigned SqSt  = 32;

  localparam logic [30:0] TrigOne = Q30One[30:0];

  // reciprocals for exact truncating division of values below 2^30
  localparam logic [31:0] Rcp90 = 32'd1527099484;
  localparam logic [31:0] Rcp72 = 32'd1908874354;
  localparam logic [31:0] Rcp56 = 32'd1227133514;
  localparam logic [31:0] Rcp42 = 32'd1636178018;
  localparam logic [31:0] Rcp30 = 32'd1145324613;
  localparam logic [31:0] Rcp20 = 32'd1717986919;
  localparam logic [31:0] Rcp12 = 32'd1431655766;
  localparam logic [31:0] Rcp6  = 32'd1431655766;

  function automatic logic [30:0] div_const(input logic [29:0] v, input logic [31:0] m,
                                            input int unsigned s);
    logic [61:0] p;
    p = {32'd0, v} * {30'd0, m};
    return 31'(p >> s);
  endfunction

  // ---- stage 0: normalize radius, angle to radians
  logic [4:0]  k_d;
  logic [31:0] y0_d;
  logic [63:0] m_d, ax_d;
  logic [21:0] a_d;
  always_comb begin
    m_d = (radius_i == 24'd0) ? 64'd1 << 24 : {40'd0, radius_i};
    k_d = 5'd0;
    for (int i = 0; i < 25; i++) if (m_d[i]) k_d = 5'(i);
    y0_d = 32'(m_d << (30 - k_d));
    a_d = angle_i[21:0];
    if ({42'd0, a_d} <= (64'd1 << 21)) ax_d = ({42'd0, a_d} * HalfPiQ30) >> 22;
    else ax_d = (((64'd1 << 22) - {42'd0, a_d}) * HalfPiQ30) >> 22;
  end

  // log pipeline with angle riding along
  logic [31:0] y_q    [LogSt+1];
  logic [19:0] f_q    [LogSt+1];
  logic [4:0]  k_q    [LogSt+1];
  logic [30:0] x_q    [LogSt+1];
  logic [1:0]  quad_q [LogSt+1];
  logic        swp_q  [LogSt+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0] <= y0_d;
      f_q[0] <= 20'd0;
      k_q[0] <= k_d;
      x_q[0] <= ax_d[30:0];
      quad_q[0] <= angle_i[23:22];
      swp_q[0] <= ({42'd0, a_d} > (64'd1 << 21));
    end
  end

  for (genvar g = 0; g < LogSt; g++) begin : g_log
    logic [63:0] sq;
    assign sq = ({32'd0, y_q[g]} * {32'd0, y_q[g]}) >> 30;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sq >= (64'd2 << 30)) begin
          y_q[g+1] <= 32'(sq >> 1);
          f_q[g+1] <= {f_q[g][18:0], 1'b1};
        end else begin
          y_q[g+1] <= sq[31:0];
          f_q[g+1] <= {f_q[g][18:0], 1'b0};
        end
        k_q[g+1] <= k_q[g];
        x_q[g+1] <= x_q[g];
        quad_q[g+1] <= quad_q[g];
        swp_q[g+1] <= swp_q[g];
      end
    end
  end

  // ---- scale to -2 ln u, start sqrt
  logic [63:0] t_d, s_d;
  logic [61:0] xx_d;
  always_comb begin
    t_d = (64'd24 << 20) - {39'd0, k_q[LogSt], f_q[LogSt]};
    s_d = (({39'd0, t_d[24:0]} * {34'd0, Ln2Q30[29:0]}) >> 29) << 24;
    xx_d = {31'd0, x_q[LogSt]} * {31'd0, x_q[LogSt]};
  end

  // sqrt pipeline, one result bit a stage; trig pipeline alongside
  logic [63:0] v_q   [SqSt+1];
  logic [63:0] res_q [SqSt+1];
  logic [30:0] tx_q  [SqSt+1];
  logic [1:0]  tq_q  [SqSt+1];
  logic        ts_q  [SqSt+1];
  logic [29:0] z_q   [SqSt+1];
  logic [30:0] ct_q  [SqSt+1];
  logic [30:0] st_q  [SqSt+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= s_d;
      res_q[0] <= 64'd0;
      tx_q[0] <= x_q[LogSt];
      tq_q[0] <= quad_q[LogSt];
      ts_q[0] <= swp_q[LogSt];
      z_q[0] <= xx_d[59:30];
      ct_q[0] <= TrigOne;
      st_q[0] <= TrigOne;
    end
  end

  for (genvar g = 0; g < SqSt; g++) begin : g_sq
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
    logic [63:0] v_n, r_n;
    logic [30:0] c_n, s_n;
    logic [60:0] zc, zs, xs;
    always_comb begin
      if (v_q[g] >= res_q[g] + Bit) begin
        v_n = v_q[g] - (res_q[g] + Bit);
        r_n = (res_q[g] >> 1) + Bit;
      end else begin
        v_n = v_q[g];
        r_n = res_q[g] >> 1;
      end
      zc = {31'd0, z_q[g]} * {30'd0, ct_q[g]};
      zs = {31'd0, z_q[g]} * {30'd0, st_q[g]};
      xs = {30'd0, tx_q[g]} * {30'd0, st_q[g]};
      c_n = ct_q[g];
      s_n = st_q[g];
      // alternate constant divides and products, one Horner term per two stages
      case (g) inside
        0: begin
          c_n = TrigOne - div_const(z_q[g], Rcp90, 37);
          s_n = TrigOne - div_const(z_q[g], Rcp72, 37);
        end
        1, 3, 5: begin
          c_n = zc[60:30];
          s_n = zs[60:30];
        end
        2: begin
          c_n = TrigOne - div_const(ct_q[g][29:0], Rcp56, 36);
          s_n = TrigOne - div_const(st_q[g][29:0], Rcp42, 36);
        end
        4: begin
          c_n = TrigOne - div_const(ct_q[g][29:0], Rcp30, 35);
          s_n = TrigOne - div_const(st_q[g][29:0], Rcp20, 35);
        end
        6: begin
          c_n = TrigOne - div_const(ct_q[g][29:0], Rcp12, 34);
          s_n = TrigOne - div_const(st_q[g][29:0], Rcp6, 33);
        end
        7: begin
          c_n = zc[60:30];
          s_n = xs[60:30];
        end
        8: c_n = TrigOne - {1'b0, ct_q[g][30:1]};
        default: ;
      endcase
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[g+1] <= v_n;
        res_q[g+1] <= r_n;
        tx_q[g+1] <= tx_q[g];
        tq_q[g+1] <= tq_q[g];
        ts_q[g+1] <= ts_q[g];
        z_q[g+1] <= z_q[g];
        ct_q[g+1] <= c_n;
        st_q[g+1] <= s_n;
      end
    end
  end

  // ---- select magnitude, multiply, clamp, sign
  logic [30:0] mag_d;
  logic [63:0] prod_d;
  logic [16:0] n_d;
  always_comb begin
    if (tq_q[SqSt][0]) mag_d = ts_q[SqSt] ? ct_q[SqSt] : st_q[SqSt];
    else               mag_d = ts_q[SqSt] ? st_q[SqSt] : ct_q[SqSt];
    prod_d = ({32'd0, res_q[SqSt][31:0]} * {33'd0, mag_d}) >> 40;
    n_d = (prod_d > 64'(SampleMax)) ? 17'(SampleMax) : prod_d[16:0];
    if (tq_q[SqSt] == 2'd1 || tq_q[SqSt] == 2'd2) n_d = -n_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) sample_o <= n_d;
  end

endmodule

// ----- rtl/layered_diffusion_walk_step.sv -----
`timescale 1ns / 1ps
// Layered diffusion walk step. Takes one tracer per cycle on the s_axis side while
// the pipeline advances and returns its new position and dead flag on the m_axis
// side (log by repeated squaring, 20 stages, and a one-bit-per-stage square root,
// 32 stages, set the depth). The pipeline advances whenever the output register is
// empty or being drained, so sustained rate is one transaction per cycle.
// Configure through APB only while no transaction is in flight; registers sit
// at byte address 8*i.
module layered_diffusion_walk_step
  import ldws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position[39:0], react_uniform[71:40], radius_uniform[95:72], angle_uniform[119:96]
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_position[39:0], dead[40], zero pad
  output logic [47:0]  m_axis_tdata
);

  localparam int unsigned GLat = 1 + 20 + 1 + 32 + 1;
  localparam int unsigned Lat  = GLat + 3;

  // ---- configuration registers
  cfg_t cfg_q;
  reg_idx_e idx;
  assign idx = reg_idx_e'(paddr[5:3]);
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_INNER_BOUNDS: cfg_q.inner_bounds     <= pwdata;
        REG_OUTER_BOUND:  cfg_q.outer_bound      <= pwdata[15:0];
        REG_ABSORB:       cfg_q.absorb_threshold <= pwdata[31:0];
        REG_STEP_LOW:     cfg_q.step_size_low    <= pwdata[59:0];
        REG_STEP_HIGH:    cfg_q.step_size_high   <= pwdata[39:0];
        REG_DRIFT_LOW:    cfg_q.drift_low        <= pwdata[59:0];
        REG_DRIFT_HIGH:   cfg_q.drift_high       <= pwdata[39:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (idx)
      REG_INNER_BOUNDS: prdata = cfg_q.inner_bounds;
      REG_OUTER_BOUND:  prdata = {48'd0, cfg_q.outer_bound};
      REG_ABSORB:       prdata = {32'd0, cfg_q.absorb_threshold};
      REG_STEP_LOW:     prdata = {4'd0, cfg_q.step_size_low};
      REG_STEP_HIGH:    prdata = {24'd0, cfg_q.step_size_high};
      REG_DRIFT_LOW:    prdata = {4'd0, cfg_q.drift_low};
      REG_DRIFT_HIGH:   prdata = {24'd0, cfg_q.drift_high};
      default:          prdata = 64'd0;
    endcase
  end

  // ---- pipeline control: advance when output is free
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld_q[Lat-1];

  logic signed [16:0] n;
  ldws_gauss u_gauss (
    .clk_i, .en_i(en),
    .radius_i(s_axis_tdata[95:72]), .angle_i(s_axis_tdata[119:96]),
    .sample_o(n)
  );

  // ---- carry position and absorb decision alongside the sample
  logic [39:0] pos_q [GLat];
  logic        abs_q [GLat];
  logic [39:0] pin;
  assign pin = s_axis_tdata[39:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= pin;
      abs_q[0] <= (pin < bound_at(cfg_q.inner_bounds, HeldLayers - 2))
                  && (s_axis_tdata[71:40] <= cfg_q.absorb_threshold);
      for (int i = 1; i < GLat; i++) begin
        pos_q[i] <= pos_q[i-1];
        abs_q[i] <= abs_q[i-1];
      end
    end
  end

  // ---- stage A: probe
  logic [LayerW-1:0] lx_d;
  logic signed [37:0] pstep_d;
  logic signed [43:0] probe_d;
  logic [40:0] pabs_d;
  always_comb begin
    lx_d = layer_of(cfg_q.inner_bounds, {1'b0, pos_q[GLat-1]});
    pstep_d = $signed({1'b0, field20(cfg_q.step_size_low, cfg_q.step_size_high, lx_d)}) * n;
    probe_d = $signed({4'd0, pos_q[GLat-1]}) + $signed({{6{pstep_d[37]}}, pstep_d});
    pabs_d = probe_d[43] ? 41'(-probe_d) : probe_d[40:0];
  end
  logic [39:0] pa_pos_q;
  logic [40:0] pa_abs_q;
  logic [LayerW-1:0] pa_lx_q;
  logic signed [16:0] pa_n_q;
  logic pa_dead_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_pos_q <= pos_q[GLat-1];
      pa_abs_q <= pabs_d;
      pa_lx_q <= lx_d;
      pa_n_q <= n;
      pa_dead_q <= abs_q[GLat-1] || ({1'b0, pabs_d} >= {2'b0, cfg_q.outer_bound, 24'd0});
    end
  end

  // ---- stage B: new position
  logic [LayerW-1:0] lp_d;
  logic signed [37:0] qstep_d;
  logic signed [44:0] q_d;
  logic [41:0] qa_d;
  always_comb begin
    lp_d = layer_of(cfg_q.inner_bounds, pa_abs_q);
    qstep_d = $signed({1'b0, field20(cfg_q.step_size_low, cfg_q.step_size_high, lp_d)})
            * pa_n_q;
    q_d = $signed({5'd0, pa_pos_q})
        + $signed({{7{qstep_d[37]}}, qstep_d})
        + $signed({25'd0, field20(cfg_q.drift_low, cfg_q.drift_high, pa_lx_q)});
    qa_d = q_d[44] ? 42'(-q_d) : q_d[41:0];
  end
  logic [41:0] pb_q;
  logic pb_dead_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q <= qa_d;
      pb_dead_q <= pa_dead_q;
    end
  end

  // ---- stage C: domain check, output register
  logic dead_d;
  assign dead_d = pb_dead_q || (pb_q <= {2'b0, bound_at(cfg_q.inner_bounds, 0)})
               || (pb_q > {2'b0, cfg_q.outer_bound, 24'd0});
  always_ff @(posedge clk_i) begin
    if (en) m_axis_tdata <= {7'd0, dead_d, dead_d ? 40'd0 : pb_q[39:0]};
  end

endmodule

// ----- test/layered_diffusion_walk_step_test.sv -----
`timescale 1ns / 1ps
module layered_diffusion_walk_step_test;
  import ldws_pkg::*;

  localparam int unsigned PipeDepth = 58;
  localparam int unsigned RandomSteps = 1130;

  typedef struct packed {
    logic [23:0] angle_uniform;
    logic [23:0] radius_uniform;
    logic [31:0] react_uniform;
    logic [39:0] position;
  } tracer_t;

  typedef struct packed {
    logic        dead;
    logic [39:0] new_position;
  } walk_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // position[39:0], react_uniform[71:40], radius_uniform[95:72], angle_uniform[119:96]
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // new_position[39:0], dead[40], zero pad
  logic [47:0]  m_axis_tdata;

  layered_diffusion_walk_step u_dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [63:0] bounds_q;
  logic [15:0] outer_q;
  logic [31:0] absorb_q;
  logic [59:0] step_lo_q;
  logic [39:0] step_hi_q;
  logic [59:0] drift_lo_q;
  logic [39:0] drift_hi_q;

  tracer_t tracer_queue[$];
  walk_t   walk_queue[$];
  int      errors = 0;
  int      walks_checked = 0;
  int      deaths_seen = 0;
  bit      calm = 1'b0;
  bit      hold_sink = 1'b0;
  bit      pipe_busy = 1'b0;

  function automatic logic [63:0] boundary(input int unsigned i);
    return {24'd0, bounds_q[16*(i%4) +: 16], 24'd0};
  endfunction

  function automatic logic [63:0] layer_rate(input logic [59:0] lo, input logic [39:0] hi,
                                              input int unsigned i);
    if (i < 3) return {44'd0, lo[20*i +: 20]};
    return {44'd0, hi[20*(i-3) +: 20]};
  endfunction

  function automatic int unsigned depth_layer(input logic [63:0] p);
    for (int unsigned i = 0; i < HeldLayers - 1; i++)
      if (p < boundary(i)) return i;
    return HeldLayers - 1;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // -2 ln(m / 2^24), Q.20
  function automatic logic [63:0] radius_log(input logic [63:0] m);
    int unsigned k;
    logic [63:0] y, frac, t;
    k = 0;
    frac = 0;
    while (k < 24 && (m >> (k + 1)) != 0) k++;
    y = m << (30 - k);
    for (int b = 0; b < 20; b++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd2 << 30)) begin
        y >>= 1;
        frac |= 1;
      end
    end
    t = (64'd24 << 20) - ((64'(k) << 20) | frac);
    return (t * 64'd744261118) >> 29;
  endfunction

  function automatic logic [63:0] cosine(input logic [63:0] x);
    logic [63:0] z, t, one;
    one = 64'd1 << 30;
    z = (x * x) >> 30;
    t = one - z / 90;
    t = one - ((z * t) >> 30) / 56;
    t = one - ((z * t) >> 30) / 30;
    t = one - ((z * t) >> 30) / 12;
    return one - ((z * t) >> 30) / 2;
  endfunction

  function automatic logic [63:0] sine(input logic [63:0] x);
    logic [63:0] z, t, one;
    one = 64'd1 << 30;
    z = (x * x) >> 30;
    t = one - z / 72;
    t = one - ((z * t) >> 30) / 42;
    t = one - ((z * t) >> 30) / 20;
    t = one - ((z * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic longint gauss(input logic [23:0] ru, input logic [23:0] au);
    logic [63:0] m, r, a, x, c, s, n;
    logic [1:0] q;
    m = (ru == 0) ? (64'd1 << 24) : 64'(ru);
    r = root64(radius_log(m) << 24);
    q = au[23:22];
    a = 64'(au[21:0]);
    if (a <= (64'd1 << 21)) begin
      x = (a * 64'd1686629713) >> 22;
      c = cosine(x);
      s = sine(x);
    end else begin
      x = (((64'd1 << 22) - a) * 64'd1686629713) >> 22;
      c = sine(x);
      s = cosine(x);
    end
    n = (r * (q[0] ? s : c)) >> 40;
    if (n > 32767) n = 32767;
    return (q == 2'd1 || q == 2'd2) ? -longint'(n) : longint'(n);
  endfunction

  function automatic walk_t advance(input tracer_t tr);
    walk_t w;
    longint n, probe, nq;
    logic [63:0] pos, outer;
    int unsigned lx, lp;
    pos = 64'(tr.position);
    outer = 64'(outer_q) << 24;
    w = '0;
    if (pos < boundary(HeldLayers - 2) && tr.react_uniform <= absorb_q) begin
      w.dead = 1'b1;
      return w;
    end
    n = gauss(tr.radius_uniform, tr.angle_uniform);
    lx = depth_layer(pos);
    probe = longint'(pos) + longint'(layer_rate(step_lo_q, step_hi_q, lx)) * n;
    if (probe < 0) probe = -probe;
    if (64'(probe) >= outer) begin
      w.dead = 1'b1;
      return w;
    end
    lp = depth_layer(64'(probe));
    nq = longint'(pos) + longint'(layer_rate(step_lo_q, step_hi_q, lp)) * n
       + longint'(layer_rate(drift_lo_q, drift_hi_q, lx));
    if (nq < 0) nq = -nq;
    if (64'(nq) <= boundary(0) || 64'(nq) > outer) w.dead = 1'b1;
    else w.new_position = nq[39:0];
    return w;
  endfunction

  // apb write, mirrored into the predictor
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_INNER_BOUNDS: bounds_q = val;
      REG_OUTER_BOUND:  outer_q = val[15:0];
      REG_ABSORB:       absorb_q = val[31:0];
      REG_STEP_LOW:     step_lo_q = val[59:0];
      REG_STEP_HIGH:    step_hi_q = val[39:0];
      REG_DRIFT_LOW:    drift_lo_q = val[59:0];
      REG_DRIFT_HIGH:   drift_hi_q = val[39:0];
      default: ;
    endcase
  endtask

  // wait for the pipe to empty before touching registers
  task automatic drain();
    while (tracer_queue.size() != 0 || pipe_busy || walk_queue.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [19:0] rand_rate();
    case ($urandom_range(3))
      0: return 20'($urandom_range(255));
      1: return 20'($urandom_range(4095));
      2: return 20'hFFFFF;
      default: return 20'($urandom());
    endcase
  endfunction

  // one layer setting with random rates, sorted unless the boundaries are randomized
  task automatic load_layers(input bit extreme);
    logic [15:0] b[4];
    logic [15:0] o;
    logic [59:0] slo, dlo;
    logic [39:0] shi, dhi;
    b[0] = 16'($urandom_range(16, 2000));
    for (int i = 1; i < 4; i++) b[i] = b[i-1] + 16'($urandom_range(16, 2000));
    o = extreme ? 16'hFFFF : b[3] + 16'($urandom_range(16, 2000));
    if ($urandom_range(4) == 0) begin
      for (int i = 0; i < 4; i++) b[i] = 16'($urandom());
    end
    slo = {rand_rate(), rand_rate(), rand_rate()};
    shi = {rand_rate(), rand_rate()};
    dlo = {rand_rate(), rand_rate(), rand_rate()};
    dhi = {rand_rate(), rand_rate()};
    write_reg(REG_INNER_BOUNDS, {b[3], b[2], b[1], b[0]});
    write_reg(REG_OUTER_BOUND, 64'(o));
    write_reg(REG_ABSORB, 64'($urandom()) >> $urandom_range(31, 2));
    write_reg(REG_STEP_LOW, 64'(slo));
    write_reg(REG_STEP_HIGH, 64'(shi));
    write_reg(REG_DRIFT_LOW, 64'(dlo));
    write_reg(REG_DRIFT_HIGH, 64'(dhi));
  endtask

  function automatic tracer_t random_tracer();
    tracer_t tr;
    logic [39:0] span;
    span = 40'(outer_q) << 24;
    tr = 120'({$urandom(), $urandom(), $urandom(), $urandom()});
    if ($urandom_range(9) != 0 && span != 0) tr.position = 40'(rand64() % 64'(span));
    if ($urandom_range(19) == 0) tr.radius_uniform = '0;
    return tr;
  endfunction

  // stimulus and register phases
  initial begin
    tracer_t tr;
    int unsigned phase_len;
    bounds_q = '0; outer_q = '0; absorb_q = '0;
    step_lo_q = '0; step_hi_q = '0; drift_lo_q = '0; drift_hi_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // outer bound zero: all survivors of absorption die
    for (int i = 0; i < 4; i++) tracer_queue.push_back(random_tracer());
    drain();

    write_reg(REG_INNER_BOUNDS, 64'h0400_0300_0200_0100);
    write_reg(REG_OUTER_BOUND, 64'h0500);
    write_reg(REG_ABSORB, 64'h8000_0000);
    write_reg(REG_STEP_LOW, {4'h0, 20'h00400, 20'h01000, 20'h04000});
    write_reg(REG_STEP_HIGH, 64'({20'h00100, 20'h00800}));
    write_reg(REG_DRIFT_LOW, {4'h0, 20'hFFFFF, 20'h00010, 20'h12345});
    write_reg(REG_DRIFT_HIGH, 64'({20'h0, 20'h54321}));

    // field extremes, zero radius, every quadrant and the half-quadrant point
    tracer_queue.push_back('{24'h000000, 24'h000000, 32'h0, 40'h0});
    tracer_queue.push_back('{24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF});
    tracer_queue.push_back('{24'h200000, 24'h000001, 32'hFFFF_FFFF, 40'h02_0000_0000});
    tracer_queue.push_back('{24'h600000, 24'h000001, 32'hFFFF_FFFF, 40'h02_8000_0000});
    tracer_queue.push_back('{24'hA00000, 24'h000001, 32'hFFFF_FFFF, 40'h03_8000_0000});
    tracer_queue.push_back('{24'hE00000, 24'h000001, 32'hFFFF_FFFF, 40'h04_8000_0000});
    tracer_queue.push_back('{24'h400000, 24'h800000, 32'h8000_0000, 40'h00_8000_0000});
    tracer_queue.push_back('{24'h800000, 24'h000100, 32'h8000_0001, 40'h01_0000_0000});
    tracer_queue.push_back('{24'hC00000, 24'h000000, 32'h0000_0000, 40'h04_FFFF_FFFF});
    tracer_queue.push_back('{24'h3FFFFF, 24'h7FFFFF, 32'h0, 40'h03_FFFF_FFFF});
    tracer_queue.push_back('{24'h200001, 24'h000001, 32'hFFFF_FFFF, 40'h05_0000_0000});
    drain();

    // unsorted boundaries, zero threshold
    write_reg(REG_INNER_BOUNDS, 64'h0100_0400_0050_0300);
    write_reg(REG_ABSORB, 64'h0);
    for (int i = 0; i < 8; i++) tracer_queue.push_back(random_tracer());
    drain();

    // full-scale registers
    write_reg(REG_INNER_BOUNDS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_OUTER_BOUND, 64'hFFFF);
    write_reg(REG_ABSORB, 64'hFFFF_FFFF);
    write_reg(REG_STEP_LOW, 64'h0FFF_FFFF_FFFF_FFFF);
    write_reg(REG_STEP_HIGH, 64'hFF_FFFF_FFFF);
    write_reg(REG_DRIFT_LOW, 64'h0FFF_FFFF_FFFF_FFFF);
    write_reg(REG_DRIFT_HIGH, 64'hFF_FFFF_FFFF);
    for (int i = 0; i < 3; i++) tracer_queue.push_back(random_tracer());
    drain();

    // random phases; the third one runs without idling and holds the sink
    for (int p = 0; p < 8; p++) begin
      load_layers(p == 7);
      calm = (p == 2);
      phase_len = RandomSteps / 8;
      for (int unsigned i = 0; i < phase_len; i++) begin
        tr = random_tracer();
        tracer_queue.push_back(tr);
      end
      if (p == 2) begin
        while (tracer_queue.size() > phase_len - 20) @(posedge clk_i);
        hold_sink = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      drain();
      calm = 1'b0;
    end

    $display("covered %0d tracer steps, %0d deaths, through %0d register settings",
             walks_checked, deaths_seen, 12);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // driver: offer pending tracers, idling now and then
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      walk_queue.push_back(advance(tracer_t'(s_axis_tdata)));
      void'(tracer_queue.pop_front());
    end
    if ((s_axis_tvalid && !s_axis_tready) || !rst_ni) begin
      // hold the current transaction
    end else if (tracer_queue.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
                 (calm || $urandom_range(99) >= 22)) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= tracer_queue[0];
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    pipe_busy <= (tracer_queue.size() != 0) || s_axis_tvalid;
  end

  // monitor: check each returned walk, stall now and then
  always @(posedge clk_i) begin
    walk_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = walk_t'(m_axis_tdata[40:0]);
      if (walk_queue.size() == 0) begin
        $error("walk result with nothing expected: %h", got);
        errors++;
      end else begin
        want = walk_queue.pop_front();
        walks_checked++;
        if (want.dead) deaths_seen++;
        if (got.new_position !== want.new_position) begin
          $error("new_position expected %h actual %h", want.new_position, got.new_position);
          errors++;
        end
        if (got.dead !== want.dead) begin
          $error("dead expected %b actual %b", want.dead, got.dead);
          errors++;
        end
      end
    end
    m_axis_tready <= rst_ni && !hold_sink && (calm || $urandom_range(99) >= 22);
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ldws_pkg.sv
rtl/ldws_gauss.sv
rtl/layered_diffusion_walk_step.sv
test/layered_diffusion_walk_step_test.sv
